/* design/smrs_pkg.sv */
// Shared types and constants for the serial memory read sequencer.
// No dependencies; every other file of the block takes names from here.
package smrs_pkg;

    // Default depth of the queue between the front and back parts
    localparam int unsigned QueueDepth = 2;

    // Field widths fixed by the serial command format
    localparam int unsigned IndexWidth   = 8;
    localparam int unsigned ByteWidth    = 8;
    localparam int unsigned AddrWidth    = 16;
    localparam int unsigned BitCntWidth  = 4;
    localparam int unsigned CfgIdxWidth  = 2;
    localparam int unsigned CfgDataWidth = 8;

    // Last bit positions of each shifted field
    localparam logic [2:0] OpcodeLastBit = 3'd7;
    localparam logic [2:0] DummyLastBit  = 3'd7;
    localparam logic [3:0] AddrLastBit   = 4'd15;
    localparam logic [2:0] DataLastBit   = 3'd7;

    // Register reset values
    localparam logic [7:0] ReadOpcodeReset    = 8'd3;
    localparam logic [7:0] AddressStrideReset = 8'd1;
    localparam logic [7:0] ReadByteCountReset = 8'd1;

    // Configuration register indexes
    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_READ_OPCODE     = 2'd0,
        CFG_ADDRESS_STRIDE  = 2'd1,
        CFG_READ_BYTE_COUNT = 2'd2
    } cfg_index_t;

    // Sequencer phases, one-hot
    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_OPCODE  = 6'b000010,
        PH_DUMMY   = 6'b000100,
        PH_ADDRESS = 6'b001000,
        PH_DATA    = 6'b010000,
        PH_DONE    = 6'b100000
    } phase_t;

    // Classified tick held in the queue
    typedef struct packed {
        logic                  fall;
        logic [IndexWidth-1:0] req_index;
        logic                  serial_in;
    } item_t;

    // Queue status seen by the front and back parts
    typedef struct packed {
        logic not_empty;
        logic not_full;
    } q_status_t;

endpackage

/* design/smrs_req_if.sv */
// Input channel of the serial memory read sequencer: one clock tick per transaction.
// Depends on smrs_pkg for field widths.
interface smrs_req_if;
    logic                            valid;
    logic                            ready;
    logic                            read_enable_n;
    logic [smrs_pkg::IndexWidth-1:0] req_index;
    logic                            serial_in;

    modport source (output valid, read_enable_n, req_index, serial_in, input ready);
    modport sink   (input valid, read_enable_n, req_index, serial_in, output ready);
endinterface

/* design/smrs_rsp_if.sv */
// Output channel of the serial memory read sequencer: one result per tick.
// Depends on smrs_pkg for field widths.
interface smrs_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           chip_select_n;
    logic                           serial_out;
    logic                           serial_out_drive;
    logic [smrs_pkg::ByteWidth-1:0] read_byte;
    logic                           byte_valid;
    logic                           done_res;

    modport source (output valid, chip_select_n, serial_out, serial_out_drive, read_byte,
                    byte_valid, done_res, input ready);
    modport sink   (input valid, chip_select_n, serial_out, serial_out_drive, read_byte,
                    byte_valid, done_res, output ready);
endinterface

/* design/serial_memory_read_sequencer_unit.sv */
// Top level of the serial memory read sequencer: front classifier, tick queue
// and back sequencer. Depends on smrs_pkg, smrs_req_if, smrs_rsp_if and submodules.
//
// Channel  Direction  Handshake         Payload
// req      in         valid/ready       read_enable_n, req_index, serial_in
// rsp      out        valid/ready       chip_select_n, serial_out, serial_out_drive,
//                                       read_byte, byte_valid, done_res
// cfg      in         cfg_we (no wait)  cfg_index, cfg_data
//
// One transaction per clock cycle in and out when neither side stalls; a tick
// goes through a queue slot and then the output register after it is accepted.
// The back sequencer steps one tick per cycle unless its output is held.
// Reset clears the queue, the enable tracker and the sequencer; no clearing pass.
// An output stall stops the sequencer; the queue then fills and drops req.ready.
module serial_memory_read_sequencer_unit #(
    parameter int unsigned QUEUE_DEPTH = smrs_pkg::QueueDepth
) (
    input  logic                              clk,
    input  logic                              rst_n,
    smrs_req_if.sink                          req,
    smrs_rsp_if.source                        rsp,
    input  logic                              cfg_we,
    input  logic [smrs_pkg::CfgIdxWidth-1:0]  cfg_index,
    input  logic [smrs_pkg::CfgDataWidth-1:0] cfg_data
);

    smrs_pkg::q_status_t q_status;
    smrs_pkg::item_t     push_item;
    smrs_pkg::item_t     pop_item;
    logic                push;
    logic                pop;

    smrs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .q_status (q_status),
        .push     (push),
        .item     (push_item)
    );

    smrs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .status    (q_status)
    );

    smrs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .item      (pop_item),
        .pop       (pop),
        .rsp       (rsp)
    );

endmodule

/* design/smrs_front.sv */
// Front part: accepts ticks and classifies each as a read-enable fall or not.
// Depends on smrs_pkg and smrs_req_if.
module smrs_front (
    input  logic                clk,
    input  logic                rst_n,
    smrs_req_if.sink            req,
    input  smrs_pkg::q_status_t q_status,
    output logic                push,
    output smrs_pkg::item_t     item
);

    logic seen_low_reg;
    logic seen_low_next;

    // Accept while the queue has room
    assign req.ready = q_status.not_full;
    assign push      = req.valid && q_status.not_full;

    // Flag a fall: enable low now, not low on the previous tick
    assign item.fall      = !req.read_enable_n && !seen_low_reg;
    assign item.req_index = req.req_index;
    assign item.serial_in = req.serial_in;

    // Track the enable level on every accepted tick
    always_comb
    begin
        seen_low_next = seen_low_reg;
        if (push)
        begin
            seen_low_next = !req.read_enable_n;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_low_reg <= 1'b0;
        end
        else
        begin
            seen_low_reg <= seen_low_next;
        end
    end

endmodule

/* design/smrs_queue.sv */
// Short FIFO of classified ticks between the front and back parts.
// Depends on smrs_pkg for the item type and status struct.
module smrs_queue #(
    parameter int unsigned DEPTH = smrs_pkg::QueueDepth
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  smrs_pkg::item_t     push_item,
    input  logic                pop,
    output smrs_pkg::item_t     pop_item,
    output smrs_pkg::q_status_t status
);

    localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntWidth = $clog2(DEPTH + 1);
    localparam logic [PtrWidth-1:0] LastPtr  = PtrWidth'(DEPTH - 1);
    localparam logic [CntWidth-1:0] FullCnt  = CntWidth'(DEPTH);

    smrs_pkg::item_t     slots [DEPTH];
    logic [PtrWidth-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrWidth-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntWidth-1:0] count_reg, count_next;

    assign status.not_empty = (count_reg != '0);
    assign status.not_full  = (count_reg != FullCnt);
    assign pop_item         = slots[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming transaction
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FullCnt)
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

    a_push_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not grow on push");

endmodule

/* design/smrs_back.sv */
// Back part: runs the read command sequencer one tick per step and holds
// the result in an output register. Depends on smrs_pkg and smrs_rsp_if.
module smrs_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [smrs_pkg::CfgIdxWidth-1:0]    cfg_index,
    input  logic [smrs_pkg::CfgDataWidth-1:0]   cfg_data,
    input  smrs_pkg::q_status_t                 q_status,
    input  smrs_pkg::item_t                     item,
    output logic                                pop,
    smrs_rsp_if.source                          rsp
);

    // Configuration registers
    logic [7:0] opcode_reg;
    logic [7:0] stride_reg;
    logic [7:0] byte_count_reg;

    // Sequencer state
    smrs_pkg::phase_t                   phase_reg, phase_next;
    logic [smrs_pkg::BitCntWidth-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [7:0]                         bytes_left_reg, bytes_left_next;
    logic [smrs_pkg::AddrWidth-1:0]     addr_reg, addr_next;
    logic [smrs_pkg::ByteWidth-1:0]     rx_shift_reg, rx_shift_next;

    // Result register
    logic                               rsp_valid_reg;
    logic                               cs_n_reg, cs_n_next;
    logic                               sout_reg, sout_next;
    logic                               drive_reg, drive_next;
    logic [smrs_pkg::ByteWidth-1:0]     rbyte_reg, rbyte_next;
    logic                               bvalid_reg, bvalid_next;
    logic                               done_reg, done_next;

    logic                               step;
    logic [2:0]                         bit_lo;
    logic [smrs_pkg::ByteWidth-1:0]     rx_acc;
    logic [7:0]                         bytes_dec;

    // Step when a tick waits and the result slot is free or draining
    assign step   = q_status.not_empty && (!rsp_valid_reg || rsp.ready);
    assign pop    = step;
    assign bit_lo = bit_cnt_reg[2:0];

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.chip_select_n    = cs_n_reg;
    assign rsp.serial_out       = sout_reg;
    assign rsp.serial_out_drive = drive_reg;
    assign rsp.read_byte        = rbyte_reg;
    assign rsp.byte_valid       = bvalid_reg;
    assign rsp.done_res         = done_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opcode_reg     <= smrs_pkg::ReadOpcodeReset;
            stride_reg     <= smrs_pkg::AddressStrideReset;
            byte_count_reg <= smrs_pkg::ReadByteCountReset;
        end
        else if (cfg_we)
        begin
            case (smrs_pkg::cfg_index_t'(cfg_index))
                smrs_pkg::CFG_READ_OPCODE:     opcode_reg     <= cfg_data;
                smrs_pkg::CFG_ADDRESS_STRIDE:  stride_reg     <= cfg_data;
                smrs_pkg::CFG_READ_BYTE_COUNT: byte_count_reg <= cfg_data;
                default:                       ;
            endcase
        end
    end

    // Merge the incoming data bit into the receive byte
    always_comb
    begin
        rx_acc         = rx_shift_reg;
        rx_acc[bit_lo] = item.serial_in;
    end

    assign bytes_dec = bytes_left_reg - 8'd1;

    // Sequencer step
    always_comb
    begin
        phase_next      = phase_reg;
        bit_cnt_next    = bit_cnt_reg;
        bytes_left_next = bytes_left_reg;
        addr_next       = addr_reg;
        rx_shift_next   = rx_shift_reg;
        cs_n_next       = 1'b1;
        sout_next       = 1'b0;
        drive_next      = 1'b0;
        rbyte_next      = '0;
        bvalid_next     = 1'b0;
        done_next       = 1'b0;

        case (phase_reg)
            smrs_pkg::PH_OPCODE:
            begin
                cs_n_next  = 1'b0;
                drive_next = 1'b1;
                sout_next  = opcode_reg[bit_lo];
                if (bit_lo == smrs_pkg::OpcodeLastBit)
                begin
                    bit_cnt_next = '0;
                    phase_next   = smrs_pkg::PH_DUMMY;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg + 1'b1;
                end
            end
            smrs_pkg::PH_DUMMY:
            begin
                cs_n_next  = 1'b0;
                drive_next = 1'b1;
                if (bit_lo == smrs_pkg::DummyLastBit)
                begin
                    bit_cnt_next = '0;
                    phase_next   = smrs_pkg::PH_ADDRESS;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg + 1'b1;
                end
            end
            smrs_pkg::PH_ADDRESS:
            begin
                cs_n_next  = 1'b0;
                drive_next = 1'b1;
                sout_next  = addr_reg[bit_cnt_reg];
                if (bit_cnt_reg == smrs_pkg::AddrLastBit)
                begin
                    bit_cnt_next  = '0;
                    rx_shift_next = '0;
                    phase_next    = (bytes_left_reg == '0) ? smrs_pkg::PH_DONE
                                                           : smrs_pkg::PH_DATA;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg + 1'b1;
                end
            end
            smrs_pkg::PH_DATA:
            begin
                cs_n_next     = 1'b0;
                rx_shift_next = rx_acc;
                if (bit_lo == smrs_pkg::DataLastBit)
                begin
                    bvalid_next     = 1'b1;
                    rbyte_next      = rx_acc;
                    bit_cnt_next    = '0;
                    bytes_left_next = bytes_dec;
                    if (bytes_dec == '0)
                    begin
                        phase_next = smrs_pkg::PH_DONE;
                    end
                end
                else
                begin
                    bit_cnt_next = {1'b0, bit_lo + 3'd1};
                end
            end
            smrs_pkg::PH_DONE:
            begin
                done_next    = 1'b1;
                bit_cnt_next = '0;
                phase_next   = smrs_pkg::PH_IDLE;
            end
            default:
            begin
                phase_next = smrs_pkg::PH_IDLE;
                if (item.fall)
                begin
                    // Latch address and byte count at the start of a read
                    addr_next       = {8'd0, item.req_index} * {8'd0, stride_reg};
                    bytes_left_next = byte_count_reg;
                    bit_cnt_next    = '0;
                    phase_next      = smrs_pkg::PH_OPCODE;
                end
            end
        endcase
    end

    // Sequencer control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= smrs_pkg::PH_IDLE;
            bit_cnt_reg    <= '0;
            bytes_left_reg <= '0;
            addr_reg       <= '0;
            rx_shift_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                phase_reg      <= phase_next;
                bit_cnt_reg    <= bit_cnt_next;
                bytes_left_reg <= bytes_left_next;
                addr_reg       <= addr_next;
                rx_shift_reg   <= rx_shift_next;
            end
            if (step)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result payload until the next step
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            cs_n_reg   <= cs_n_next;
            sout_reg   <= sout_next;
            drive_reg  <= drive_next;
            rbyte_reg  <= rbyte_next;
            bvalid_reg <= bvalid_next;
            done_reg   <= done_next;
        end
    end

    a_drive_needs_select: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && drive_reg |-> !cs_n_reg)
        else $error("serial_out driven with chip select high");

    a_done_alone: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(done_reg && bvalid_reg) && !(done_reg && drive_reg))
        else $error("done pulse overlaps a byte or a driven bit");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == smrs_pkg::PH_DONE |=> phase_reg == smrs_pkg::PH_IDLE)
        else $error("sequencer did not return to idle after done");

    a_step_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> q_status.not_empty)
        else $error("sequencer stepped without a queued tick");

endmodule

/* tb/serial_memory_read_sequencer_unit_tb.sv */
// Self-checking testbench for the serial memory read sequencer top level.
// Needs smrs_pkg, smrs_req_if, smrs_rsp_if and serial_memory_read_sequencer_unit.
// A directed table runs first, then random read commands, all checked per tick.
module serial_memory_read_sequencer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One clock tick offered to the block
    typedef struct packed {
        logic                            ren_n;
        logic [smrs_pkg::IndexWidth-1:0] idx;
        logic                            sin;
    } tick_t;

    // Pin values the block reports for one tick
    typedef struct packed {
        logic                           cs_n;
        logic                           sout;
        logic                           drive;
        logic [smrs_pkg::ByteWidth-1:0] rbyte;
        logic                           bvalid;
        logic                           done;
    } pins_t;

    typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

    // Directed row: a register write or a run of identical ticks
    typedef struct packed {
        row_kind_t             kind;
        smrs_pkg::cfg_index_t  cfg_reg;
        logic [7:0]            cfg_val;
        logic [7:0]            reps;
        tick_t                 tick;
        logic                  typed;
        pins_t                 want;
    } dir_row_t;

    localparam smrs_pkg::cfg_index_t RegOpcode = smrs_pkg::CFG_READ_OPCODE;
    localparam smrs_pkg::cfg_index_t RegStride = smrs_pkg::CFG_ADDRESS_STRIDE;
    localparam smrs_pkg::cfg_index_t RegCount  = smrs_pkg::CFG_READ_BYTE_COUNT;

    localparam pins_t IdleOut = '{1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0};
    localparam pins_t DoneOut = '{1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1};

    localparam int unsigned RandomTicks = 800;
    localparam int unsigned TopTicks = 200;
    localparam int unsigned HoldAtResult = 400;
    localparam int unsigned HoldCycles = 250;

    // Columns: kind, register, value, repeat, {ren_n, index, serial_in}, typed, expected
    dir_row_t dir_table [0:25] = '{
        // after reset, then a read with the reset settings, the level low as it ends
        '{ROW_TICK, RegOpcode, 8'h00, 8'd2, '{1'b1, 8'h00, 1'b0}, 1'b1, IdleOut},
        '{ROW_TICK, RegOpcode, 8'h00, 8'd1, '{1'b0, 8'hFF, 1'b1}, 1'b1, IdleOut},
        '{ROW_TICK, RegOpcode, 8'h00, 8'd8, '{1'b0, 8'h00, 1'b1}, 1'b0, IdleOut},
        '{ROW_TICK, RegOpcode, 8'h00, 8'd8, '{1'b1, 8'h00, 1'b1}, 1'b0, IdleOut},
        '{ROW_TICK, RegOpcode, 8'h00, 8'd16, '{1'b1, 8'h55, 1'b0}, 1'b0, IdleOut},
        '{ROW_TICK, RegOpcode, 8'h00, 8'd8, '{1'b0, 8'hAA, 1'b1}, 1'b0, IdleOut},
        '{ROW_TICK, RegOpcode, 8'h00, 8'd1, '{1'b0, 8'h00, 1'b0}, 1'b1, DoneOut},
        // level still low after done: no restart
        '{ROW_TICK, RegOpcode, 8'h00, 8'd3, '{1'b0, 8'h01, 1'b0}, 1'b1, IdleOut},
        '{ROW_TICK, RegOpcode, 8'h00, 8'd1, '{1'b1, 8'h00, 1'b0}, 1'b1, IdleOut},
        // zero byte count, top stride, opcode rewritten in the middle of its phase
        '{ROW_CFG, RegOpcode, 8'h00, 8'd0, '{1'b1, 8'h00, 1'b0}, 1'b0, IdleOut},
        '{ROW_CFG, RegStride, 8'hFF, 8'd0, '{1'b1, 8'h00, 1'b0}, 1'b0, IdleOut},
        '{ROW_CFG, RegCount, 8'h00, 8'd0, '{1'b1, 8'h00, 1'b0}, 1'b0, IdleOut},
        '{ROW_TICK, RegOpcode, 8'h00, 8'd1, '{1'b0, 8'hFF, 1'b0}, 1'b1, IdleOut},
        '{ROW_TICK, RegOpcode, 8'h00, 8'd4, '{1'b1, 8'h00, 1'b1}, 1'b0, IdleOut},
        '{ROW_CFG, RegOpcode, 8'hFF, 8'd0, '{1'b1, 8'h00, 1'b0}, 1'b0, IdleOut},
        '{ROW_TICK, RegOpcode, 8'h00, 8'd28, '{1'b1, 8'h00, 1'b1}, 1'b0, IdleOut},
        '{ROW_TICK, RegOpcode, 8'h00, 8'd1, '{1'b1, 8'h00, 1'b0}, 1'b1, DoneOut},
        '{ROW_TICK, RegOpcode, 8'h00, 8'd2, '{1'b1, 8'h00, 1'b0}, 1'b1, IdleOut},
        // two bytes at stride zero, requests while busy
        '{ROW_CFG, RegCount, 8'h02, 8'd0, '{1'b1, 8'h00, 1'b0}, 1'b0, IdleOut},
        '{ROW_CFG, RegStride, 8'h00, 8'd0, '{1'b1, 8'h00, 1'b0}, 1'b0, IdleOut},
        '{ROW_TICK, RegOpcode, 8'h00, 8'd1, '{1'b0, 8'h80, 1'b0}, 1'b1, IdleOut},
        '{ROW_TICK, RegOpcode, 8'h00, 8'd32, '{1'b1, 8'h7F, 1'b0}, 1'b0, IdleOut},
        '{ROW_TICK, RegOpcode, 8'h00, 8'd8, '{1'b1, 8'h00, 1'b1}, 1'b0, IdleOut},
        '{ROW_TICK, RegOpcode, 8'h00, 8'd8, '{1'b0, 8'h00, 1'b0}, 1'b0, IdleOut},
        '{ROW_TICK, RegOpcode, 8'h00, 8'd1, '{1'b0, 8'h00, 1'b0}, 1'b1, DoneOut},
        '{ROW_TICK, RegOpcode, 8'h00, 8'd2, '{1'b1, 8'h00, 1'b0}, 1'b1, IdleOut}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [smrs_pkg::CfgIdxWidth-1:0] cfg_index;
    logic [smrs_pkg::CfgDataWidth-1:0] cfg_data;

    smrs_req_if req_ch ();
    smrs_rsp_if rsp_ch ();

    serial_memory_read_sequencer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Predictor copy of the registers and the sequencer state
    logic [7:0]        opcode_reg;
    logic [7:0]        stride_reg;
    logic [7:0]        count_reg;
    logic              seen_low;
    smrs_pkg::phase_t  seq_phase;
    logic [4:0]        bit_cnt;
    logic [7:0]        bytes_left;
    logic [15:0]       addr_reg;
    logic [7:0]        rx_shift;

    pins_t pins_due [$];

    int unsigned tx_mode = 0;
    int unsigned rx_mode = 0;
    int unsigned ticks_sent = 0;
    int unsigned random_ticks = 0;
    int unsigned settings_used = 1;
    int unsigned reads_started = 0;
    int unsigned bytes_due = 0;
    int unsigned dones_due = 0;
    int unsigned results_seen = 0;
    int unsigned bad_results = 0;
    int unsigned leftover = 0;
    int unsigned in_stall_run = 0;
    int unsigned in_stall_max = 0;

    // Work out the pins for one tick and advance the predicted state
    function automatic pins_t predict_pins(input tick_t t);
        pins_t      p;
        logic       fall;
        logic [3:0] k;
        logic [2:0] b;
        p = IdleOut;
        fall = !t.ren_n && !seen_low;
        k = bit_cnt[3:0];
        b = k[2:0];
        case (seq_phase)
            smrs_pkg::PH_OPCODE:
            begin
                p.cs_n = 1'b0;
                p.drive = 1'b1;
                p.sout = opcode_reg[b];
                if (b == smrs_pkg::OpcodeLastBit)
                begin
                    bit_cnt = '0;
                    seq_phase = smrs_pkg::PH_DUMMY;
                end
                else
                    bit_cnt = 5'(k + 4'd1);
            end
            smrs_pkg::PH_DUMMY:
            begin
                p.cs_n = 1'b0;
                p.drive = 1'b1;
                if (b == smrs_pkg::DummyLastBit)
                begin
                    bit_cnt = '0;
                    seq_phase = smrs_pkg::PH_ADDRESS;
                end
                else
                    bit_cnt = 5'(k + 4'd1);
            end
            smrs_pkg::PH_ADDRESS:
            begin
                p.cs_n = 1'b0;
                p.drive = 1'b1;
                p.sout = addr_reg[k];
                if (k == smrs_pkg::AddrLastBit)
                begin
                    bit_cnt = '0;
                    rx_shift = '0;
                    seq_phase = (bytes_left == 0) ? smrs_pkg::PH_DONE : smrs_pkg::PH_DATA;
                end
                else
                    bit_cnt = 5'(k + 4'd1);
            end
            smrs_pkg::PH_DATA:
            begin
                p.cs_n = 1'b0;
                rx_shift[b] = t.sin;
                if (b == smrs_pkg::DataLastBit)
                begin
                    p.bvalid = 1'b1;
                    p.rbyte = rx_shift;
                    bytes_due++;
                    bit_cnt = '0;
                    bytes_left = bytes_left - 8'd1;
                    if (bytes_left == 0)
                        seq_phase = smrs_pkg::PH_DONE;
                end
                else
                    bit_cnt = 5'(b + 3'd1);
            end
            smrs_pkg::PH_DONE:
            begin
                p.done = 1'b1;
                dones_due++;
                bit_cnt = '0;
                seq_phase = smrs_pkg::PH_IDLE;
            end
            default:
            begin
                seq_phase = smrs_pkg::PH_IDLE;
                if (fall)
                begin
                    addr_reg = {8'h00, t.idx} * {8'h00, stride_reg};
                    bytes_left = count_reg;
                    bit_cnt = '0;
                    seq_phase = smrs_pkg::PH_OPCODE;
                    reads_started++;
                end
            end
        endcase
        seen_low = !t.ren_n;
        return p;
    endfunction

    // Draw a wait in cycles: none, fully random, or mostly none
    function automatic int unsigned draw_gap(input int unsigned mode);
        if (mode == 0)
            return 0;
        if (mode == 1)
            return $urandom_range(0, 14);
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
    endfunction

    // Mostly well-formed reads: fall while idle, level mostly high while busy
    function automatic tick_t draw_tick();
        tick_t t;
        t.idx = 8'($urandom);
        t.sin = 1'($urandom);
        if (seq_phase == smrs_pkg::PH_IDLE)
            t.ren_n = ($urandom_range(0, 9) < 7) ? seen_low : 1'($urandom);
        else
            t.ren_n = ($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
        return t;
    endfunction

    // Offer one tick, hold it until accepted, then record its expected pins
    task automatic send_tick(input tick_t t, input bit typed, input pins_t want);
        int unsigned gap;
        pins_t       calc;
        gap = draw_gap(tx_mode);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.read_enable_n <= t.ren_n;
        req_ch.req_index <= t.idx;
        req_ch.serial_in <= t.sin;
        @(posedge clk);
        while (req_ch.ready !== 1'b1) @(posedge clk);
        calc = predict_pins(t);
        pins_due.push_back(typed ? want : calc);
        ticks_sent++;
    endtask

    // Drain all outstanding transactions, then write one register
    task automatic write_reg(input smrs_pkg::cfg_index_t which, input logic [7:0] value);
        req_ch.valid <= 1'b0;
        while (pins_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= which;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (which)
            smrs_pkg::CFG_READ_OPCODE:     opcode_reg = value;
            smrs_pkg::CFG_ADDRESS_STRIDE:  stride_reg = value;
            smrs_pkg::CFG_READ_BYTE_COUNT: count_reg = value;
            default:                       ;
        endcase
    endtask

    // Pick idling modes and rewrite some registers, now and then at an extreme
    task automatic choose_settings();
        logic [7:0] v;
        tx_mode = $urandom_range(0, 2);
        rx_mode = $urandom_range(0, 2);
        if ($urandom_range(0, 3) != 0)
        begin
            v = ($urandom_range(0, 4) == 0) ? {8{1'($urandom)}} : 8'($urandom);
            write_reg(RegOpcode, v);
        end
        if ($urandom_range(0, 3) != 0)
        begin
            v = ($urandom_range(0, 4) == 0) ? {8{1'($urandom)}} : 8'($urandom);
            write_reg(RegStride, v);
        end
        if ($urandom_range(0, 3) != 0)
        begin
            v = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 5));
            write_reg(RegCount, v);
        end
        settings_used++;
    endtask

    // Track the longest run of input back-pressure
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && !req_ch.ready)
        begin
            in_stall_run <= in_stall_run + 1;
            if (in_stall_run + 1 > in_stall_max)
                in_stall_max <= in_stall_run + 1;
        end
        else
            in_stall_run <= 0;
    end

    // Result side: random stalls, one long hold-off, compare against the oldest expectation
    initial
    begin : result_sink
        pins_t       got;
        pins_t       want;
        int unsigned stall;
        bit          held;
        held = 1'b0;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held && results_seen >= HoldAtResult)
            begin
                stall = HoldCycles;
                held = 1'b1;
            end
            else
                stall = draw_gap(rx_mode);
            if (stall != 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (rsp_ch.valid !== 1'b1) @(posedge clk);
            got = '{rsp_ch.chip_select_n, rsp_ch.serial_out, rsp_ch.serial_out_drive,
                    rsp_ch.read_byte, rsp_ch.byte_valid, rsp_ch.done_res};
            results_seen++;
            if (pins_due.size() == 0)
            begin
                bad_results++;
                if (bad_results <= 10)
                    $display("%0t: result %0d arrived with nothing expected", $realtime,
                             results_seen);
            end
            else
            begin
                want = pins_due.pop_front();
                if (got !== want)
                begin
                    bad_results++;
                    if (bad_results <= 10)
                    begin
                        $display("%0t: result %0d mismatch", $realtime, results_seen);
                        $display("  expected cs_n=%b out=%b drv=%b byte=%h bv=%b done=%b",
                                 want.cs_n, want.sout, want.drive, want.rbyte,
                                 want.bvalid, want.done);
                        $display("  actual   cs_n=%b out=%b drv=%b byte=%h bv=%b done=%b",
                                 got.cs_n, got.sout, got.drive, got.rbyte,
                                 got.bvalid, got.done);
                    end
                end
            end
        end
    end

    // Stimulus: reset, directed table, random settings and reads, then wind down
    initial
    begin : stimulus
        tick_t       t;
        int unsigned budget;
        int unsigned n;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = RegOpcode;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.read_enable_n = 1'b1;
        req_ch.req_index = '0;
        req_ch.serial_in = 1'b0;
        opcode_reg = smrs_pkg::ReadOpcodeReset;
        stride_reg = smrs_pkg::AddressStrideReset;
        count_reg = smrs_pkg::ReadByteCountReset;
        seen_low = 1'b0;
        seq_phase = smrs_pkg::PH_IDLE;
        bit_cnt = '0;
        bytes_left = '0;
        addr_reg = '0;
        rx_shift = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (int r = 0; r <= 25; r++)
        begin
            if (dir_table[r].kind == ROW_CFG)
                write_reg(dir_table[r].cfg_reg, dir_table[r].cfg_val);
            else
                repeat (dir_table[r].reps)
                    send_tick(dir_table[r].tick, dir_table[r].typed, dir_table[r].want);
        end

        // Random reads under changing settings
        while (random_ticks < RandomTicks)
        begin
            choose_settings();
            budget = $urandom_range(60, 160);
            repeat (budget)
            begin
                t = draw_tick();
                send_tick(t, 1'b0, IdleOut);
                random_ticks++;
            end
        end

        // Top of every register: a long read, cut short by the end of stimulus
        tx_mode = 2;
        rx_mode = 2;
        write_reg(RegOpcode, 8'hFF);
        write_reg(RegStride, 8'hFF);
        write_reg(RegCount, 8'hFF);
        settings_used++;
        repeat (TopTicks)
        begin
            t = draw_tick();
            send_tick(t, 1'b0, IdleOut);
        end

        // Wait for the tail of the pipeline, with a bound
        req_ch.valid <= 1'b0;
        n = 0;
        while (pins_due.size() != 0 && n < 2000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (8) @(posedge clk);
        leftover = pins_due.size();
        if (leftover != 0)
            $display("%0d expected results never arrived", leftover);

        $display("Covered %0d ticks under %0d register settings:", ticks_sent, settings_used);
        $display("  %0d reads, %0d data bytes, %0d done pulses; input stalled up to %0d cycles.",
                 reads_started, bytes_due, dones_due, in_stall_max);
        if (bad_results == 0 && leftover == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #6_000_000;
        $display("timeout with %0d transactions outstanding", pins_due.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule
